// File: sv/sos_pkg.sv
// ----------------------------------------------------------------------------
// sos_pkg: shared constants and helpers for the strided order-statistic select
// Store geometry, status codes and the IEEE single-precision ordering.
// ----------------------------------------------------------------------------
`default_nettype none
package sos_pkg;
  localparam int unsigned StoreDepth = 4096;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned CntW       = $clog2(StoreDepth + 1);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  localparam logic [0:0] REG_STRIDE = 1'b0;
  localparam logic [0:0] REG_RANK   = 1'b1;

  // Strict IEEE less-than on bit patterns; plus and minus zero compare equal.
  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    logic bz;
    begin
      bz = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      if (bz) f_lt = 1'b0;
      else if (a[31] != b[31]) f_lt = a[31];
      else if (!a[31]) f_lt = a[30:0] < b[30:0];
      else f_lt = a[30:0] > b[30:0];
    end
  endfunction
endpackage
`default_nettype wire

// File: sv/strided_order_statistic_select_core.sv
// ----------------------------------------------------------------------------
// strided_order_statistic_select_core: strided sampling plus quickselect
// Keeps every stride-th float sample and returns the element of a given rank.
// ----------------------------------------------------------------------------
// Input: one transfer per cycle, back to back, while loading. After the last
// transfer Hoare FIND runs through one single-port RAM: an element visit is a
// read then a compare, a swap writes slot i then slot j, a partition pass adds a
// pivot read, capture and narrowing; a final read fetches slot q. An empty or
// overflowed vector answers the next cycle. Input waits until the result moves.
// Reset (rst_n low, synchronous) clears counters, flags, stride 1, rank 0.
`default_nettype none
module strided_order_statistic_select_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // sample[31:0]
  input  wire logic        in_tlast,   // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // selected[31:0], status[33:32], zero pad
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import sos_pkg::*;

  // One-hot sequencer. Pivot read, then the two scans, then swap, then
  // narrowing of the window.
  typedef enum logic [11:0] {
    S_LOAD  = 12'b000000000001,
    S_PRD   = 12'b000000000010,
    S_PWT   = 12'b000000000100,
    S_IRD   = 12'b000000001000,
    S_ICMP  = 12'b000000010000,
    S_JRD   = 12'b000000100000,
    S_JCMP  = 12'b000001000000,
    S_SWI   = 12'b000010000000,
    S_SWJ   = 12'b000100000000,
    S_NEXT  = 12'b001000000000,
    S_QRD   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [15:0]     stride_r, rank_r;
  logic [CntW-1:0] kept_r, kept_nxt;
  logic [15:0]     phase_r, phase_nxt;
  logic            ovf_r, ovf_nxt;
  // Signed window indices: j may fall to -1.
  logic signed [CntW:0] lo_r, hi_r, i_r, j_r, q_r;
  logic signed [CntW:0] lo_nxt, hi_nxt, i_nxt, j_nxt, q_nxt;
  logic signed [CntW:0] idx_one;
  logic [31:0]     piv_r, piv_nxt, vi_r, vi_nxt, res_r, res_nxt;
  logic [1:0]      stat_r, stat_nxt;

  logic            ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [31:0]     ram_wdata, ram_rdata;
  logic [15:0]     eff_stride;
  logic            in_xfer;

  sos_ram #(.Width(32), .Depth(StoreDepth)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign idx_one    = $signed((CntW+1)'(1));
  assign eff_stride = (stride_r == 16'd0) ? 16'd1 : stride_r;
  assign in_tready  = (state_r == S_LOAD) && !out_tvalid;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tdata  = {6'd0, stat_r, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= 16'd1;
      rank_r   <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRIDE: stride_r <= cfg_data;
        REG_RANK:   rank_r   <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r; kept_nxt = kept_r; phase_nxt = phase_r; ovf_nxt = ovf_r;
    lo_nxt = lo_r; hi_nxt = hi_r; i_nxt = i_r; j_nxt = j_r; q_nxt = q_r;
    piv_nxt = piv_r; vi_nxt = vi_r; res_nxt = res_r; stat_nxt = stat_r;
    ram_we = 1'b0; ram_addr = '0; ram_wdata = in_tdata;
    unique case (state_r)
      S_LOAD: begin
        ram_addr = kept_r[AddrW-1:0];
        if (in_xfer) begin
          ram_we = (phase_r == 16'd0) && (kept_r < CntW'(StoreDepth));
          if ({1'b0, phase_r} + 17'd1 >= {1'b0, eff_stride}) begin
            phase_nxt = 16'd0;
            if (kept_r < CntW'(StoreDepth)) kept_nxt = kept_r + CntW'(1);
            else ovf_nxt = 1'b1;
          end else begin
            phase_nxt = phase_r + 16'd1;
          end
          if (in_tlast) begin
            res_nxt = 32'd0;
            if (ovf_nxt) begin
              stat_nxt = ST_OVF; state_nxt = S_OUT;
            end else if (kept_nxt == '0) begin
              stat_nxt = ST_EMPTY; state_nxt = S_OUT;
            end else begin
              stat_nxt = ST_OK;
              lo_nxt = '0;
              hi_nxt = $signed({1'b0, kept_nxt - CntW'(1)});
              // The rank is compared at full width before it is narrowed.
              q_nxt  = ({1'b0, rank_r} < 17'(kept_nxt))
                       ? $signed({1'b0, rank_r[CntW-1:0]})
                       : $signed({1'b0, kept_nxt - CntW'(1)});
              state_nxt = S_PRD;
            end
          end
        end
      end
      S_PRD: begin
        if (lo_r < hi_r) begin
          ram_addr = q_r[AddrW-1:0];
          i_nxt = lo_r; j_nxt = hi_r;
          state_nxt = S_PWT;
        end else begin
          ram_addr = q_r[AddrW-1:0];
          state_nxt = S_QRD;
        end
      end
      S_PWT: begin
        piv_nxt = ram_rdata;
        state_nxt = S_IRD;
      end
      S_IRD: begin
        ram_addr = i_r[AddrW-1:0];
        state_nxt = S_ICMP;
      end
      S_ICMP: begin
        vi_nxt = ram_rdata;
        if (i_r < hi_r && f_lt(ram_rdata, piv_r)) begin
          i_nxt = i_r + idx_one; state_nxt = S_IRD;
        end else begin
          state_nxt = S_JRD;
        end
      end
      S_JRD: begin
        ram_addr = j_r[AddrW-1:0];
        state_nxt = S_JCMP;
      end
      S_JCMP: begin
        if (j_r > lo_r && f_lt(piv_r, ram_rdata)) begin
          j_nxt = j_r - idx_one; state_nxt = S_JRD;
        end else if (i_r <= j_r) begin
          // Write the j value into slot i now; the old i value waits in vi for slot j.
          ram_we = 1'b1; ram_addr = i_r[AddrW-1:0]; ram_wdata = ram_rdata;
          state_nxt = S_SWJ;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_SWJ: begin
        ram_we = 1'b1; ram_addr = j_r[AddrW-1:0]; ram_wdata = vi_r;
        i_nxt = i_r + idx_one; j_nxt = j_r - idx_one;
        state_nxt = (i_r + idx_one <= j_r - idx_one) ? S_IRD : S_NEXT;
      end
      S_SWI: state_nxt = S_NEXT;
      S_NEXT: begin
        if (j_r < q_r) lo_nxt = i_r;
        if (q_r < i_r) hi_nxt = j_r;
        state_nxt = S_PRD;
      end
      S_QRD: begin
        res_nxt = ram_rdata;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        kept_nxt = '0; phase_nxt = 16'd0; ovf_nxt = 1'b0;
        if (out_tready) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  assign out_tvalid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      kept_r  <= '0;
      phase_r <= 16'd0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kept_r  <= kept_nxt;
      phase_r <= phase_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt; hi_r <= hi_nxt; i_r <= i_nxt; j_r <= j_nxt; q_r <= q_nxt;
    piv_r <= piv_nxt; vi_r <= vi_nxt; res_r <= res_nxt; stat_r <= stat_nxt;
  end
endmodule
`default_nettype wire

// File: sv/sos_ram.sv
// ----------------------------------------------------------------------------
// sos_ram: generic single-port synchronous RAM
// Each cycle one address is read and, if we is set, written; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module sos_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: tb/tb_strided_order_statistic_select_core.sv
// ----------------------------------------------------------------------------
// tb_strided_order_statistic_select_core: self-checking bench for the selector
// Streams float vectors under several stride and rank settings, predicts the
// selected element with an in-bench strided store and Hoare partition, and
// compares every result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_strided_order_statistic_select_core;
  import sos_pkg::*;

  localparam int DEPTH = 4096;
  localparam int STALL_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // sample[31:0]
  logic        in_tlast = 1'b0; // last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // selected[31:0], status[33:32], zero pad
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_STRIDE;
  logic [15:0] cfg_data = '0;

  strided_order_statistic_select_core dut (.*);

  always #4 clk = ~clk;

  // Copy of the block state used to predict results.
  logic [31:0] shadow_store [DEPTH];
  int          kept_n;
  int          phase_n;
  bit          ovf_seen;
  int unsigned stride_reg = 1;
  int unsigned rank_reg = 0;

  // Expected selections, oldest first.
  logic [31:0] want_sel [$];
  logic [1:0]  want_stat [$];

  int  errors = 0;
  int  sent_items = 0;
  int  results_seen = 0;
  int  vectors_sent = 0;
  bit  calm = 1'b0;     // when set, neither side idles or stalls
  int  quiet_cycles = 0;

  // Total order key for non-NaN floats; both zeros map to the same key.
  function automatic longint order_key(input logic [31:0] b);
    return b[31] ? -longint'(b[30:0]) : longint'(b[30:0]);
  endfunction

  // In-place Hoare FIND over the shadow store, returns the entry at slot q.
  function automatic logic [31:0] hoare_pick(input int n, input int q);
    int lo, hi, i, j;
    longint pv;
    logic [31:0] t;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      pv = order_key(shadow_store[q]);
      i = lo;
      j = hi;
      do begin
        while (i < hi && order_key(shadow_store[i]) < pv) i++;
        while (j > lo && order_key(shadow_store[j]) > pv) j--;
        if (i <= j) begin
          t = shadow_store[i];
          shadow_store[i] = shadow_store[j];
          shadow_store[j] = t;
          i++;
          j--;
        end
      end while (i <= j);
      if (j < q) lo = i;
      if (q < i) hi = j;
    end
    return shadow_store[q];
  endfunction

  // Advance the shadow state by one accepted sample; queue a result on last.
  task automatic absorb_sample(input logic [31:0] s, input logic lst);
    int unsigned eff;
    int q;
    eff = (stride_reg == 0) ? 1 : stride_reg;
    if (phase_n == 0 && kept_n < DEPTH) shadow_store[kept_n] = s;
    if (phase_n + 1 >= eff) begin
      if (kept_n < DEPTH) kept_n++;
      else ovf_seen = 1'b1;
      phase_n = 0;
    end else begin
      phase_n++;
    end
    if (lst) begin
      if (ovf_seen) begin
        want_sel.push_back('0);
        want_stat.push_back(ST_OVF);
      end else if (kept_n == 0) begin
        want_sel.push_back('0);
        want_stat.push_back(ST_EMPTY);
      end else begin
        q = (rank_reg < kept_n) ? rank_reg : kept_n - 1;
        want_sel.push_back(hoare_pick(kept_n, q));
        want_stat.push_back(ST_OK);
      end
      kept_n = 0;
      phase_n = 0;
      ovf_seen = 1'b0;
      vectors_sent++;
    end
  endtask

  // Offer one sample and hold it until the block takes it. Unless calm is set,
  // each cycle idles with the same chance, so idle cycles make up about 31 percent.
  task automatic send_sample(input logic [31:0] s, input logic lst);
    while (!calm && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_sample(s, lst);
    sent_items++;
  endtask

  // Wait until every expected result has come, then let the block settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    wait (want_sel.size() == 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input int unsigned val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_STRIDE) stride_reg = val & 16'hFFFF;
    else rank_reg = val & 16'hFFFF;
  endtask

  // Random float without NaN; some draws come from a small pool so that
  // duplicates and signed zeros show up often.
  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(5))
          0: v = 32'h0000_0000;
          1: v = 32'h8000_0000;
          2: v = 32'h3F80_0000;
          3: v = 32'hBF80_0000;
          4: v = 32'h7F80_0000;
          default: v = 32'hFF80_0000;
        endcase
      end
      1: v = {1'($urandom_range(1)), 8'd127, 19'd0, 4'($urandom_range(15))};
      default: v = $urandom;
    endcase
    if (v[30:23] == 8'hFF) v[22:0] = '0;
    return v;
  endfunction

  task automatic send_vector(input int len);
    for (int k = 0; k < len; k++) send_sample(rand_float(), k == len - 1);
  endtask

  // Extremes of the sample field, signed zeros, infinities, rank clamping,
  // stride zero, an empty selection and the widest stride.
  task automatic test_directed();
    write_reg(REG_STRIDE, 1);
    write_reg(REG_RANK, 0);
    send_sample(32'h7F80_0000, 1'b1);
    write_reg(REG_RANK, 2);
    send_sample(32'hFF80_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7F7F_FFFF, 1'b0);
    send_sample(32'h8000_0001, 1'b0);
    send_sample(32'hFFFF_FFFF & 32'hFF7F_FFFF, 1'b1);
    write_reg(REG_RANK, 65535);
    send_sample(32'h4000_0000, 1'b0);
    send_sample(32'hC000_0000, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
    write_reg(REG_STRIDE, 0);
    send_sample(32'h3F80_0000, 1'b0);
    send_sample(32'h3F00_0000, 1'b1);
    write_reg(REG_STRIDE, 3);
    send_sample(32'h1234_5678, 1'b0);
    send_sample(32'h8765_4321, 1'b1);
    send_sample(32'h4040_0000, 1'b0);
    send_sample(32'h4080_0000, 1'b0);
    send_sample(32'h40A0_0000, 1'b0);
    send_sample(32'h40C0_0000, 1'b0);
    send_sample(32'h40E0_0000, 1'b1);
    write_reg(REG_STRIDE, 65535);
    send_sample(32'h5555_5555, 1'b0);
    send_sample(32'h2AAA_AAAA, 1'b1);
  endtask

  // More kept samples than the store holds must report an overflow.
  task automatic test_overflow();
    write_reg(REG_STRIDE, 1);
    write_reg(REG_RANK, 5);
    calm = 1'b1;
    for (int k = 0; k < DEPTH + 3; k++) send_sample($urandom, 1'b0);
    send_sample($urandom, 1'b1);
    calm = 1'b0;
    // A store filled exactly to the brim is still fine.
    for (int k = 0; k < DEPTH; k++) send_sample(32'(k), k == DEPTH - 1);
  endtask

  // Random vectors under a sequence of register settings.
  task automatic test_random();
    int phase_no;
    phase_no = 0;
    while (sent_items < 650 + 2 * DEPTH) begin
      write_reg(REG_STRIDE, (phase_no % 4 == 3) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 4));
      write_reg(REG_RANK, (phase_no % 3 == 2) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 12));
      calm = (phase_no == 2);
      for (int v = 0; v < 6; v++) begin
        // The sender holds off here until the block has answered everything.
        if (v == 3) drain_results();
        send_vector($urandom_range(1, 30));
      end
      phase_no++;
    end
    calm = 1'b0;
  endtask

  // Result side: stall at random unless calm is set, and compare each result transfer.
  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (want_sel.size() == 0) begin
        errors++;
        $display("%0t: unexpected result selected=%h status=%0d", $time,
                 out_tdata[31:0], out_tdata[33:32]);
      end else begin
        if (out_tdata[31:0] !== want_sel[0]) begin
          errors++;
          $display("%0t: selected expected %h actual %h", $time, want_sel[0],
                   out_tdata[31:0]);
        end
        if (out_tdata[33:32] !== want_stat[0]) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want_stat[0],
                   out_tdata[33:32]);
        end
        void'(want_sel.pop_front());
        void'(want_stat.pop_front());
      end
    end
  end

  // Watchdog: give up after a long stretch with no transfer of any kind.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, want_sel.size());
      $display("strided_order_statistic_select_core: mismatch");
      $finish;
    end
  end

  initial begin
    kept_n = 0;
    phase_n = 0;
    ovf_seen = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random();
    drain_results();
    repeat (50) @(posedge clk);
    $display("Covered %0d sample transfers in %0d vectors, %0d results checked,",
             sent_items, vectors_sent, results_seen);
    $display("including empty, overflow, clamped-rank and zero-stride cases.");
    if (errors == 0 && want_sel.size() == 0) begin
      $display("strided_order_statistic_select_core: match");
    end else begin
      $display("strided_order_statistic_select_core: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
sv/sos_pkg.sv
sv/sos_ram.sv
sv/strided_order_statistic_select_core.sv
tb/tb_strided_order_statistic_select_core.sv
